@@ hw/rtl/prime_sieve_counter_assert.svh @@
// Assertion macros for the prime sieve counter.
// Expects clk and arst_n in the scope where a macro is used.
// Synthesis builds define SYNTHESIS and get empty bodies.
`ifndef PRIME_SIEVE_COUNTER_ASSERT_SVH
`define PRIME_SIEVE_COUNTER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PSC_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("psc assertion failed");

// next-cycle implication
`define PSC_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("psc assertion failed");

`else

`define PSC_ASSERT_NOW(lbl, pre, post)
`define PSC_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

@@ hw/rtl/psc_pkg.sv @@
// Package for the prime sieve counter: sizes, widths and types.
// No dependencies.
`default_nettype none

package psc_pkg;

	// largest limit the flag store covers; requests above it saturate
	localparam int MAX_LIMIT = 65535;
	localparam int DEPTH     = MAX_LIMIT + 1;
	localparam int ADDR_W    = $clog2(DEPTH);

	localparam int LIMIT_W     = 16;
	localparam int COUNT_W     = 13;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 16;

	// width for comparing the request against MAX_LIMIT
	localparam int CMP_W = (ADDR_W > LIMIT_W) ? ADDR_W : LIMIT_W;

	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [ADDR_W:0]    addr_ext_t;
	typedef logic [COUNT_W-1:0] count_t;

endpackage

`default_nettype wire

@@ hw/rtl/prime_sieve_counter.sv @@
// Prime sieve counter: top level with sequencer and one-bit flag memory.
// Depends on psc_pkg and prime_sieve_counter_assert.svh.
//
// Usage:
//   Slave stream (s_*) carries one request: the upper limit in s_tdata[15:0].
//   Master stream (m_*) returns one result per request: the number of primes
//   from 2 to the limit inclusive, in m_tdata[12:0], upper bits zero.
//   Limits above MAX_LIMIT are clamped to MAX_LIMIT.
// Sequence (lim = clamped limit): a limit below 2 goes straight to the
//   done state. Otherwise the sequencer fills flags 0..lim, issues the
//   first read at index 2, scans 2..lim, clears the multiples (from 2i up
//   to lim) of each prime i it finds, then hands the result to the output
//   register.
//   The single flag memory (one write and one registered read per cycle)
//   sets the pace: every fill, scan and clear step is one memory access.
//   s_tready is high only while the sequencer is idle, so one request is in
//   work at a time.
// Stall: the result sits in an output register; a new request is taken while
//   it waits. If the next result is ready before the old one is taken, the
//   sequencer holds in its done state until m_tready frees the register.
// Reset: arst_n clears the sequencer and the output valid. The flag memory
//   is not cleared; every request fills it before reading it.
`default_nettype none
`include "prime_sieve_counter_assert.svh"

module prime_sieve_counter (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	input  wire  [psc_pkg::IN_TDATA_W-1:0]    s_tdata,   // [15:0] upper_limit
	output logic                              m_tvalid,
	input  wire                               m_tready,
	output logic [psc_pkg::OUT_TDATA_W-1:0]   m_tdata    // [12:0] prime_count
);

	import psc_pkg::*;

	// sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;  // waiting for a request
	localparam logic [2:0] ST_FILL  = 3'd1;  // set flags 0..lim
	localparam logic [2:0] ST_PRIME = 3'd2;  // issue first read at index 2
	localparam logic [2:0] ST_SCAN  = 3'd3;  // test flag of i, prefetch i+1
	localparam logic [2:0] ST_MARK  = 3'd4;  // clear multiples of stride
	localparam logic [2:0] ST_DONE  = 3'd5;  // hand result to output register

	logic [2:0]  state_q;
	addr_t       lim_q;
	addr_t       i_q;        // fill / scan index
	addr_ext_t   k_q;        // multiple being cleared
	addr_t       stride_q;   // prime whose multiples are cleared
	count_t      count_q;

	logic        m_tvalid_q;
	count_t      result_q;

	// flag memory
	logic        mem_q [DEPTH];
	logic        we;
	addr_t       waddr;
	logic        wdata;
	logic        re;
	addr_t       raddr;
	logic        flag_q;     // registered read data

	// request decode with saturation
	logic [CMP_W-1:0] req_wide;
	addr_t            req_lim;
	logic             accept;
	logic             result_free;
	addr_ext_t        twice_i;
	addr_ext_t        k_next;
	logic             scan_last;

	assign req_wide    = CMP_W'(s_tdata[LIMIT_W-1:0]);
	assign req_lim     = (req_wide > CMP_W'(MAX_LIMIT)) ? ADDR_W'(MAX_LIMIT)
	                                                    : req_wide[ADDR_W-1:0];
	assign s_tready    = (state_q == ST_IDLE);
	assign accept      = s_tvalid && s_tready;
	assign result_free = !m_tvalid_q || m_tready;

	assign twice_i   = {i_q, 1'b0};
	assign k_next    = k_q + {1'b0, stride_q};
	assign scan_last = (i_q == lim_q);

	// memory port control
	always_comb begin
		we    = 1'b0;
		waddr = i_q;
		wdata = 1'b1;
		re    = 1'b0;
		raddr = i_q + ADDR_W'(1);
		unique case (state_q)
			ST_FILL: begin
				we = 1'b1;
			end
			ST_PRIME: begin
				re    = 1'b1;
				raddr = ADDR_W'(2);
			end
			ST_SCAN: begin
				// prefetch next index; clears of i only hit 2i and up
				re = !scan_last;
			end
			ST_MARK: begin
				we    = 1'b1;
				waddr = k_q[ADDR_W-1:0];
				wdata = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			flag_q <= mem_q[raddr];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (req_lim < ADDR_W'(2)) ? ST_DONE : ST_FILL;
					end
				end
				ST_FILL: begin
					if (scan_last) begin
						state_q <= ST_PRIME;
					end
				end
				ST_PRIME: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (flag_q && (twice_i <= {1'b0, lim_q})) begin
						state_q <= ST_MARK;
					end else if (scan_last) begin
						state_q <= ST_DONE;
					end
				end
				ST_MARK: begin
					// i_q already points at the next candidate, never the last+1
					if (k_next > {1'b0, lim_q}) begin
						state_q <= ST_SCAN;
					end
				end
				ST_DONE: begin
					if (result_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				lim_q   <= req_lim;
				i_q     <= '0;
				count_q <= '0;
			end
			ST_FILL: begin
				if (scan_last) begin
					i_q <= ADDR_W'(2);
				end else begin
					i_q <= i_q + ADDR_W'(1);
				end
			end
			ST_SCAN: begin
				if (flag_q) begin
					count_q <= count_q + COUNT_W'(1);
				end
				if (flag_q && (twice_i <= {1'b0, lim_q})) begin
					k_q      <= twice_i;
					stride_q <= i_q;
				end
				if (!scan_last) begin
					i_q <= i_q + ADDR_W'(1);
				end
			end
			ST_MARK: begin
				k_q <= k_next;
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_DONE && result_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && result_free) begin
			result_q <= count_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_TDATA_W'(result_q);

	// checks
	`PSC_ASSERT_NOW(a_mark_in_range, state_q == ST_MARK, k_q <= {1'b0, lim_q})
	`PSC_ASSERT_NOW(a_index_in_range, state_q == ST_FILL || state_q == ST_SCAN, i_q <= lim_q)
	`PSC_ASSERT_NOW(a_stride_min, state_q == ST_MARK, stride_q >= ADDR_W'(2))
	`PSC_ASSERT_NOW(a_count_below_index, state_q == ST_SCAN, ADDR_W'(count_q) < i_q)
	`PSC_ASSERT_NEXT(a_done_loads, state_q == ST_DONE && result_free, m_tvalid)

endmodule

`default_nettype wire
